@@ hw/rtl/sobel_edge_magnitude_macros.svh @@
// Assertion macros for the Sobel edge magnitude top level.
`ifndef SOBEL_EDGE_MAGNITUDE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define SEM_ASSERT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define SEM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/sem_pkg.sv @@
// Types and constants shared by the Sobel edge magnitude modules.
`timescale 1ns / 1ps

package sem_pkg;

  // Item command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // Register indexes (paddr bit 2)
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Register field width and reset values
  localparam int          CFG_W        = 12;
  localparam logic [11:0] RESET_WIDTH  = 12'd640;
  localparam logic [11:0] RESET_HEIGHT = 12'd480;

  // Window queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QAW         = $clog2(QUEUE_DEPTH);
  localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic       cmd;
    logic [7:0] pixel;
  } pix_item_t;

  typedef struct packed {
    logic [7:0] edge_res;
    logic       row_end;
    logic       frame_end;
  } res_item_t;

  // Border-clamped 3x3 neighborhood, px[row*3 + col]
  typedef struct packed {
    logic [8:0][7:0] px;
    logic            row_end;
    logic            frame_end;
  } win_t;

endpackage

@@ hw/rtl/sem_queue.sv @@
// Small FIFO of clamped windows between the front and the back.
`timescale 1ns / 1ps

module sem_queue import sem_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  win_t           push_item,
  input  logic           pop,
  output win_t           head,
  output logic [QCW-1:0] count,
  output logic           empty
);

  win_t           ent [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head  = ent[rd_ptr];
  assign empty = (count == '0);

endmodule

@@ hw/rtl/sem_front.sv @@
// Front end: accepts items, keeps counters, line stores and the 3x3 window.
`timescale 1ns / 1ps

module sem_front import sem_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  localparam int CB = $clog2(MAX_WIDTH),
  localparam int WW = CB + 1,
  localparam int RB = $clog2(MAX_HEIGHT),
  localparam int HW = RB + 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           pix_valid,
  output logic           pix_stall,
  input  pix_item_t      pix_item,
  input  logic [WW-1:0]  eff_w,
  input  logic [HW-1:0]  eff_h,
  input  logic           restart,
  input  logic [QCW-1:0] q_count,
  output logic           q_push,
  output win_t           q_item
);

  localparam logic [QCW:0] FULL_MARK = (QCW + 1)'(QUEUE_DEPTH);

  // Stream counters
  logic [CB-1:0] in_column, in_column_next;
  logic [HW-1:0] in_row, in_row_next;
  logic [CB-1:0] out_column, out_column_next;
  logic [RB-1:0] out_row, out_row_next;

  // Line stores
  logic [7:0] upper_mem  [MAX_WIDTH];
  logic [7:0] middle_mem [MAX_WIDTH];
  logic [7:0] rd_upper;
  logic [7:0] rd_middle;

  // Second stage
  logic          s1_valid;
  logic          s1_emit;
  logic [CB-1:0] s1_col;
  logic [7:0]    s1_bot;
  logic          s1_left, s1_right, s1_top, s1_bottom;
  logic          s1_fwd;
  logic [7:0]    fwd_top, fwd_mid;
  logic [7:0]    top_val, mid_val;

  logic [2:0][2:0][7:0] win;

  logic accept, is_drain, in_done, apply, started;
  logic in_last, out_right, out_bottom;

  // Room for this item and the one in the second stage
  assign pix_stall = ({1'b0, q_count} + {{QCW{1'b0}}, s1_valid}) >= FULL_MARK;

  // Classify the item against the stream position
  always_comb begin
    accept     = pix_valid && !pix_stall;
    is_drain   = (pix_item.cmd == CMD_DRAIN);
    in_done    = (in_row >= eff_h);
    apply      = accept && (is_drain == in_done);
    started    = (in_row >= HW'(2)) || ((in_row == HW'(1)) && (in_column != '0));
    in_last    = ({1'b0, in_column} + WW'(1)) >= eff_w;
    out_right  = ({1'b0, out_column} + WW'(1)) >= eff_w;
    out_bottom = ({1'b0, out_row} + HW'(1)) >= eff_h;
  end

  // Counter update
  always_comb begin
    in_column_next  = in_column;
    in_row_next     = in_row;
    out_column_next = out_column;
    out_row_next    = out_row;
    if (apply) begin
      if (in_last) begin
        in_column_next = '0;
        in_row_next    = in_row + 1'b1;
      end else begin
        in_column_next = in_column + 1'b1;
      end
      if (started) begin
        if (out_right && out_bottom) begin
          in_column_next  = '0;
          in_row_next     = '0;
          out_column_next = '0;
          out_row_next    = '0;
        end else if (out_right) begin
          out_column_next = '0;
          out_row_next    = out_row + 1'b1;
        end else begin
          out_column_next = out_column + 1'b1;
        end
      end
    end
    if (restart) begin
      in_column_next  = '0;
      in_row_next     = '0;
      out_column_next = '0;
      out_row_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
      s1_valid   <= 1'b0;
    end else begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
      s1_valid   <= apply;
    end
  end

  // First stage payload; fwd marks a read that misses the write in flight
  always_ff @(posedge clk) begin
    if (apply) begin
      s1_emit   <= started;
      s1_col    <= in_column;
      s1_bot    <= is_drain ? 8'd0 : pix_item.pixel;
      s1_left   <= (out_column == '0);
      s1_right  <= out_right;
      s1_top    <= (out_row == '0);
      s1_bottom <= out_bottom;
      s1_fwd    <= s1_valid && (s1_col == in_column);
    end
  end

  // Line store read at accept, write back in the following cycle
  always_ff @(posedge clk) begin
    if (apply) begin
      rd_upper  <= upper_mem[in_column];
      rd_middle <= middle_mem[in_column];
    end
    if (s1_valid) begin
      upper_mem[s1_col]  <= mid_val;
      middle_mem[s1_col] <= s1_bot;
    end
  end

  assign top_val = s1_fwd ? fwd_top : rd_upper;
  assign mid_val = s1_fwd ? fwd_mid : rd_middle;

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      fwd_top <= mid_val;
      fwd_mid <= s1_bot;
    end
  end

  // Window shift
  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_valid) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= top_val;
      win[1][2] <= mid_val;
      win[2][2] <= s1_bot;
    end
  end

  // Clamp to edge on the shifted window and hand it to the queue
  always_comb begin
    logic [2:0][7:0]      fresh;
    logic [2:0][2:0][7:0] ecol;
    logic [2:0][2:0][7:0] erow;
    fresh[0] = top_val;
    fresh[1] = mid_val;
    fresh[2] = s1_bot;
    for (int r = 0; r < 3; r++) begin
      ecol[r][0] = s1_left ? win[r][2] : win[r][1];
      ecol[r][1] = win[r][2];
      ecol[r][2] = s1_right ? win[r][2] : fresh[r];
    end
    for (int c = 0; c < 3; c++) begin
      erow[0][c] = s1_top ? ecol[1][c] : ecol[0][c];
      erow[1][c] = ecol[1][c];
      erow[2][c] = s1_bottom ? ecol[1][c] : ecol[2][c];
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        q_item.px[r * 3 + c] = erow[r][c];
      end
    end
    q_item.row_end   = s1_right;
    q_item.frame_end = s1_right && s1_bottom;
    q_push           = s1_valid && s1_emit;
  end

endmodule

@@ hw/rtl/sem_back.sv @@
// Back end: Sobel sums, squares and saturating integer square root.
`timescale 1ns / 1ps

module sem_back import sem_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  win_t      head,
  input  logic      q_empty,
  output logic      q_pop,
  output logic      res_valid,
  input  logic      res_stall,
  output res_item_t res_item
);

  typedef struct packed {
    logic [7:0] root;
    logic [8:0] rem;
  } sq_t;

  // Four digits of the restoring square root, two radicand bits each
  function automatic sq_t sqrt4(input sq_t acc, input logic [7:0] bits_in);
    logic [10:0] r;
    logic [10:0] t;
    logic [7:0]  q;
    sq_t         o;
    r = {2'b00, acc.rem};
    q = acc.root;
    for (int i = 3; i >= 0; i--) begin
      r = {r[8:0], bits_in[2 * i + 1 -: 2]};
      t = {1'b0, q, 2'b01};
      if (r >= t) begin
        r = r - t;
        q = {q[6:0], 1'b1};
      end else begin
        q = {q[6:0], 1'b0};
      end
    end
    o.root = q;
    o.rem  = r[8:0];
    return o;
  endfunction

  logic v1, v2, v3, v4, v5;
  logic en;

  logic [1:0]         fl1, fl2, fl3, fl4, fl5;
  logic signed [10:0] gx1, gy1;
  logic [19:0]        sqx2, sqy2;
  logic [15:0]        rad3;
  logic               sat3, sat4;
  sq_t                acc4;
  logic [7:0]         lo4;
  logic [7:0]         edge5;

  logic [9:0]         pos_x, neg_x, pos_y, neg_y;
  logic signed [21:0] prod_x, prod_y;
  logic [20:0]        sum2;
  sq_t                root5;

  // Whole pipe moves unless a result waits at the output
  assign en    = !(v5 && res_stall);
  assign q_pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= q_pop;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Kernel sums
  always_comb begin
    pos_x = {2'b00, head.px[2]} + {1'b0, head.px[5], 1'b0} + {2'b00, head.px[8]};
    neg_x = {2'b00, head.px[0]} + {1'b0, head.px[3], 1'b0} + {2'b00, head.px[6]};
    pos_y = {2'b00, head.px[6]} + {1'b0, head.px[7], 1'b0} + {2'b00, head.px[8]};
    neg_y = {2'b00, head.px[0]} + {1'b0, head.px[1], 1'b0} + {2'b00, head.px[2]};
  end

  assign prod_x = 22'(gx1) * 22'(gx1);
  assign prod_y = 22'(gy1) * 22'(gy1);
  assign sum2   = {1'b0, sqx2} + {1'b0, sqy2};
  assign root5  = sqrt4(acc4, lo4);

  always_ff @(posedge clk) begin
    if (en) begin
      // gradients
      gx1  <= $signed({1'b0, pos_x}) - $signed({1'b0, neg_x});
      gy1  <= $signed({1'b0, pos_y}) - $signed({1'b0, neg_y});
      fl1  <= {head.row_end, head.frame_end};
      // squares
      sqx2 <= prod_x[19:0];
      sqy2 <= prod_y[19:0];
      fl2  <= fl1;
      // sum, saturate above 16 bits
      rad3 <= sum2[15:0];
      sat3 <= |sum2[20:16];
      fl3  <= fl2;
      // upper root digits
      acc4 <= sqrt4('0, rad3[15:8]);
      lo4  <= rad3[7:0];
      sat4 <= sat3;
      fl4  <= fl3;
      // lower root digits
      edge5 <= sat4 ? 8'hFF : root5.root;
      fl5   <= fl4;
    end
  end

  assign res_valid          = v5;
  assign res_item.edge_res  = edge5;
  assign res_item.row_end   = fl5[1];
  assign res_item.frame_end = fl5[0];

endmodule

@@ hw/rtl/sobel_edge_magnitude.sv @@
// Top level of the streaming 3x3 Sobel edge magnitude block.
`timescale 1ns / 1ps

// Streaming Sobel edge magnitude. Pixels arrive in raster order, one per item,
// for a frame of frame_width x frame_height (zero counts as 1, values above
// MAX_WIDTH / MAX_HEIGHT are clipped). Each result is min(255, isqrt(gx^2+gy^2))
// with clamp-to-edge borders and appears frame_width+1 stream positions after
// its center pixel, so after the last pixel the user sends frame_width+1 drain
// items to flush the final row; pixels past the frame end and drains before it
// are taken and dropped. The block takes one item per clock and gives one
// result per clock while the output is not stalled: the two line stores are
// single memories read when an item is taken and written back the next cycle,
// and a result is offered once the item that completes it has passed the
// line-store read stage, the four-entry window queue and five back stages.
// Writing either register restarts the frame; write registers only while
// the block is idle.

`include "sobel_edge_magnitude_macros.svh"

module sobel_edge_magnitude import sem_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic        clk,
  input  logic        rst,
  // pixel channel
  input  logic        pix_valid,
  output logic        pix_stall,
  input  pix_item_t   pix_item,
  // result channel
  output logic        res_valid,
  input  logic        res_stall,
  output res_item_t   res_item,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int WW = $clog2(MAX_WIDTH) + 1;
  localparam int HW = $clog2(MAX_HEIGHT) + 1;

  logic [CFG_W-1:0] frame_width_reg;
  logic [CFG_W-1:0] frame_height_reg;
  logic [WW-1:0]    eff_w;
  logic [HW-1:0]    eff_h;
  logic             cfg_write;

  logic           q_push;
  logic           q_pop;
  logic           q_empty;
  logic [QCW-1:0] q_count;
  win_t           q_in;
  win_t           q_head;

  // Register writes
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width_reg  <= RESET_WIDTH;
      frame_height_reg <= RESET_HEIGHT;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: frame_height_reg <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = {{(32 - CFG_W){1'b0}}, frame_width_reg};
      REG_FRAME_HEIGHT: prdata = {{(32 - CFG_W){1'b0}}, frame_height_reg};
      default:          prdata = '0;
    endcase
  end

  // Effective frame size
  always_comb begin
    if (frame_width_reg == '0) begin
      eff_w = WW'(1);
    end else if (32'(frame_width_reg) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width_reg);
    end
    if (frame_height_reg == '0) begin
      eff_h = HW'(1);
    end else if (32'(frame_height_reg) > 32'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(frame_height_reg);
    end
  end

  sem_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_item  (pix_item),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .restart   (cfg_write),
    .q_count   (q_count),
    .q_push    (q_push),
    .q_item    (q_in)
  );

  sem_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .count     (q_count),
    .empty     (q_empty)
  );

  sem_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  // Checks
  `SEM_ASSERT(q_no_overflow, q_push && !q_pop, q_count < QCW'(QUEUE_DEPTH), "window queue overflow")
  `SEM_ASSERT(q_no_underflow, q_pop, !q_empty, "pop from empty window queue")
  `SEM_ASSERT(back_frozen_on_stall, res_valid && res_stall, !q_pop, "back end popped while held")
  `SEM_ASSERT_NEXT(push_lands, q_push, !q_empty, "pushed window missing from queue")

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the streaming Sobel edge magnitude block.
`timescale 1ns / 1ps

module tb_top;
  import sem_pkg::*;

  localparam int          MAX_DIM       = 2048;
  localparam int          RANDOM_ITEMS  = 1300;
  localparam int          EDGE_RUN      = 100;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          QUIET_LIMIT   = 4000;
  localparam int          KX[9]         = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
  localparam int          KY[9]         = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};
  localparam int          IDLE_PICK[3]  = '{0, 3, 14};

  // DUT connections, all inputs known from time zero
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        pix_valid = 1'b0;
  logic        pix_stall;
  pix_item_t   pix_item  = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  res_item_t   res_item;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  // Stimulus and scoreboard state
  pix_item_t   pixel_q[$];
  res_item_t   expected_edges[$];
  int unsigned items_sent    = 0;
  int unsigned items_taken   = 0;
  int unsigned mismatches    = 0;
  int unsigned send_gap_max  = 14;
  int unsigned res_stall_max = 14;
  int unsigned hold_req      = 0;
  int unsigned quiet_cycles  = 0;

  // Shadow of the block: registers, line stores, window and counters
  logic [11:0] width_reg  = RESET_WIDTH;
  logic [11:0] height_reg = RESET_HEIGHT;
  logic [7:0]  upper_line[MAX_DIM];
  logic [7:0]  middle_line[MAX_DIM];
  logic [7:0]  win[3][3];
  int unsigned in_col  = 0;
  int unsigned in_rw   = 0;
  int unsigned out_col = 0;
  int unsigned out_rw  = 0;

  sobel_edge_magnitude DUT (
    .clk      (clk),
    .rst      (rst),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .pix_item (pix_item),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_item (res_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #10 clk = ~clk;

  // Zero counts as 1, anything past the store size is clipped
  function automatic int unsigned eff_dim(input logic [11:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // floor(sqrt(s)), saturated at 255
  function automatic logic [7:0] magnitude_root(input int unsigned s);
    int unsigned r;
    int unsigned t;
    if (s >= 65536) return 8'd255;
    r = 0;
    for (int b = 7; b >= 0; b--) begin
      t = r | (1 << b);
      if (t * t <= s) r = t;
    end
    return r[7:0];
  endfunction

  // Register write restarts the frame
  function automatic void apply_frame_reg(input logic idx, input logic [11:0] val);
    if (idx == REG_FRAME_WIDTH) width_reg = val;
    else height_reg = val;
    in_col = 0;
    in_rw = 0;
    out_col = 0;
    out_rw = 0;
  endfunction

  // Advance the shadow by one accepted item, queue the result it causes
  function automatic void predict_edge(input pix_item_t it);
    int unsigned w;
    int unsigned h;
    int unsigned ci;
    int          gx;
    int          gy;
    logic        drain;
    logic [7:0]  top;
    logic [7:0]  mid;
    logic [7:0]  bot;
    logic [7:0]  nb[3][3];
    longint unsigned pos;
    res_item_t   res;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    drain = (it.cmd == CMD_DRAIN);
    // pixels past the frame and drains inside it are dropped
    if (drain != (in_rw >= h)) return;

    top = upper_line[in_col];
    mid = middle_line[in_col];
    bot = drain ? 8'd0 : it.pixel;
    upper_line[in_col] = mid;
    middle_line[in_col] = bot;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = bot;

    pos = longint'(in_rw) * w + in_col;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_rw++;
    end
    if (pos < w + 1) return;

    // clamp to edge: columns first, then rows
    for (int c = 0; c < 3; c++) begin
      ci = c;
      if (c == 0 && out_col == 0) ci = 1;
      if (c == 2 && out_col + 1 >= w) ci = 1;
      for (int r = 0; r < 3; r++) nb[r][c] = win[r][ci];
      if (out_rw == 0) nb[0][c] = nb[1][c];
      if (out_rw + 1 >= h) nb[2][c] = nb[1][c];
    end
    gx = 0;
    gy = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        gx += int'(nb[r][c]) * KX[r*3 + c];
        gy += int'(nb[r][c]) * KY[r*3 + c];
      end
    end
    res.edge_res  = magnitude_root(gx * gx + gy * gy);
    res.row_end   = (out_col + 1 >= w);
    res.frame_end = res.row_end && (out_rw + 1 >= h);
    expected_edges.push_back(res);

    if (res.frame_end) begin
      out_col = 0;
      out_rw = 0;
      in_col = 0;
      in_rw = 0;
    end else if (res.row_end) begin
      out_col = 0;
      out_rw++;
    end else begin
      out_col++;
    end
  endfunction

  function automatic void report_field(input string name, input int unsigned want,
                                       input logic [7:0] got);
    $display("%t edge result mismatch on %s: expected %0d, actual %0d",
             $time, name, want, got);
    mismatches++;
  endfunction

  // Sender: presents queued items with a random gap before each one
  int unsigned gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (pix_valid && !pix_stall) begin
        predict_edge(pix_item);
        items_taken++;
      end
      if (!pix_valid || !pix_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          pix_valid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          pix_item  <= pixel_q.pop_front();
          pix_valid <= 1'b1;
          gap_left = $urandom_range(0, send_gap_max);
        end else begin
          pix_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result, stalls at random, holds off on request
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;
  int unsigned hold_seen  = 0;
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_edges.size() == 0) begin
          $display("%t unexpected edge result: edge_res %0d row_end %0d frame_end %0d",
                   $time, res_item.edge_res, res_item.row_end, res_item.frame_end);
          mismatches++;
        end else begin
          res_item_t want;
          want = expected_edges.pop_front();
          if (res_item.edge_res !== want.edge_res)
            report_field("edge_res", want.edge_res, res_item.edge_res);
          if (res_item.row_end !== want.row_end)
            report_field("row_end", want.row_end, res_item.row_end);
          if (res_item.frame_end !== want.frame_end)
            report_field("frame_end", want.frame_end, res_item.frame_end);
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        if (res_valid && !res_stall) stall_left = $urandom_range(0, res_stall_max);
        else if (stall_left != 0) stall_left--;
        res_stall <= (stall_left != 0);
      end
    end
  end

  // Watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst || (pix_valid && !pix_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%t no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("** sobel_edge_magnitude: FAILED **");
        $finish;
      end
    end
  end

  task automatic push_item(input logic cmd, input logic [7:0] px);
    pix_item_t it;
    it.cmd = cmd;
    it.pixel = px;
    pixel_q.push_back(it);
    items_sent++;
  endtask

  // Block is idle: every item taken, every result seen, pipeline flushed
  task automatic wait_idle();
    while (items_taken != items_sent || expected_edges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_check(input logic idx, input logic [11:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[11:0] !== val) begin
      $display("%t register %0d readback: expected %0d, actual %0d",
               $time, idx, val, prdata[11:0]);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_write(input logic idx, input logic [11:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {20'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    apply_frame_reg(idx, val);
    cfg_check(idx, val);
  endtask

  // One frame in raster order plus the flush unless cut short, with dropped items mixed in
  task automatic queue_frame(input int unsigned w, input int unsigned h,
                             input logic cut_short, input int style,
                             inout int unsigned useful);
    int unsigned n;
    int unsigned stop;
    int          base;
    int          v;
    logic [7:0]  px;
    n = w * h;
    stop = cut_short ? $urandom_range(0, n - 1) : n;
    base = $urandom_range(0, 255);
    for (int unsigned k = 0; k < stop; k++) begin
      if ($urandom_range(0, 19) == 0) push_item(CMD_DRAIN, 8'($urandom));
      case (style)
        0: px = 8'($urandom);
        1: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        2: begin
          v = base + int'($urandom_range(0, 6)) - 3;
          px = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
        end
        default: px = 8'((k % w) * 37 + (k / w) * 11 + base);
      endcase
      push_item(CMD_PIXEL, px);
    end
    useful += stop;
    if (!cut_short) begin
      for (int unsigned d = 0; d <= w; d++) begin
        if ($urandom_range(0, 7) == 0) push_item(CMD_PIXEL, 8'($urandom));
        push_item(CMD_DRAIN, 8'($urandom));
      end
      if ($urandom_range(0, 3) == 0) push_item(CMD_DRAIN, 8'($urandom));
      useful += w + 1;
    end
  endtask

  initial begin
    int unsigned useful;
    int unsigned frames;
    logic [11:0] wv;
    logic [11:0] hv;
    logic        first;

    foreach (upper_line[i]) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    foreach (win[r, c]) win[r][c] = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset values, then a partial frame cut off by a register write
    cfg_check(REG_FRAME_WIDTH, RESET_WIDTH);
    cfg_check(REG_FRAME_HEIGHT, RESET_HEIGHT);
    push_item(CMD_PIXEL, 8'd0);
    push_item(CMD_PIXEL, 8'd255);
    wait_idle();

    // Zero sizes act as a single pixel; the extra pixel and the drain past the flush are dropped
    cfg_write(REG_FRAME_WIDTH, 12'd0);
    cfg_write(REG_FRAME_HEIGHT, 12'd0);
    push_item(CMD_PIXEL, 8'd255);
    push_item(CMD_PIXEL, 8'd0);
    push_item(CMD_DRAIN, 8'd255);
    push_item(CMD_DRAIN, 8'd0);
    push_item(CMD_DRAIN, 8'd170);
    wait_idle();

    // 3x3 checkerboard of the extremes: saturated and zero magnitudes
    cfg_write(REG_FRAME_WIDTH, 12'd3);
    cfg_write(REG_FRAME_HEIGHT, 12'd3);
    push_item(CMD_DRAIN, 8'd85);
    for (int k = 0; k < 9; k++) push_item(CMD_PIXEL, (k % 2) ? 8'd255 : 8'd0);
    push_item(CMD_DRAIN, 8'd0);
    push_item(CMD_DRAIN, 8'd0);
    push_item(CMD_PIXEL, 8'd255);
    push_item(CMD_DRAIN, 8'd255);
    push_item(CMD_DRAIN, 8'd0);
    wait_idle();

    // Frame broken off mid-row, next write restarts it
    cfg_write(REG_FRAME_WIDTH, 12'd4);
    cfg_write(REG_FRAME_HEIGHT, 12'd2);
    push_item(CMD_PIXEL, 8'd255);
    push_item(CMD_PIXEL, 8'd1);
    push_item(CMD_PIXEL, 8'd128);
    push_item(CMD_PIXEL, 8'd254);
    push_item(CMD_PIXEL, 8'd127);
    push_item(CMD_PIXEL, 8'd0);
    wait_idle();

    // Random frames; the first one runs against a long receiver hold-off
    useful = 0;
    first = 1'b1;
    while (useful < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       wv = 12'd0;
        1:       wv = $urandom_range(13, 48);
        default: wv = $urandom_range(1, 10);
      endcase
      case ($urandom_range(0, 9))
        0:       hv = 12'd0;
        1:       hv = $urandom_range(7, 16);
        default: hv = $urandom_range(1, 5);
      endcase
      if (first) begin
        wv = 12'd40;
        hv = 12'd5;
      end
      case ($urandom_range(0, 3))
        0: cfg_write(REG_FRAME_WIDTH, wv);
        1: cfg_write(REG_FRAME_HEIGHT, hv);
        default: begin
          cfg_write(REG_FRAME_WIDTH, wv);
          cfg_write(REG_FRAME_HEIGHT, hv);
        end
      endcase
      send_gap_max  = IDLE_PICK[$urandom_range(0, 2)];
      res_stall_max = IDLE_PICK[$urandom_range(0, 2)];
      if (first) begin
        send_gap_max  = 0;
        res_stall_max = 0;
        hold_req++;
        first = 1'b0;
      end
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++)
        queue_frame(eff_dim(width_reg), eff_dim(height_reg),
                    (f == frames - 1) && ($urandom_range(0, 6) == 0),
                    $urandom_range(0, 3), useful);
      wait_idle();
    end

    // Largest sizes, cut short: width above the store size, then the tallest frame
    send_gap_max  = 3;
    res_stall_max = 3;
    cfg_write(REG_FRAME_WIDTH, 12'hFFF);
    cfg_write(REG_FRAME_HEIGHT, 12'd1);
    for (int k = 0; k < EDGE_RUN; k++) push_item(CMD_PIXEL, 8'($urandom));
    wait_idle();
    cfg_write(REG_FRAME_WIDTH, 12'd1);
    cfg_write(REG_FRAME_HEIGHT, 12'hFFF);
    for (int k = 0; k < EDGE_RUN; k++) push_item(CMD_PIXEL, 8'(k * 7));
    wait_idle();

    if (mismatches == 0 && expected_edges.size() == 0) begin
      $display("** sobel_edge_magnitude: PASSED **");
    end else begin
      $display("** sobel_edge_magnitude: FAILED **");
    end
    $finish;
  end

endmodule
